// ===== src/frta_pkg.sv =====
// Shared constants and the digit-to-character function of the radix-to-ASCII converter.
package frta_pkg;

    localparam int INT_BITS_DEF        = 24;
    localparam int FRAC_BITS_DEF       = 16;
    localparam int MAX_FRAC_DIGITS_DEF = 16;

    localparam int DIGIT_W = 6;
    localparam int LIMIT_W = 5;
    localparam int CHAR_W  = 8;

    localparam logic [DIGIT_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [DIGIT_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [DIGIT_W-1:0] RADIX_RESET = 6'd2;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd5;

    localparam logic CFG_RADIX      = 1'b0;
    localparam logic CFG_FRAC_LIMIT = 1'b1;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_A     = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_POINT = 8'h2E;
    localparam logic [DIGIT_W-1:0] DEC_BASE  = 6'd10;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DEC_BASE) begin
            c = CHAR_ZERO + {2'b00, d};
        end else begin
            c = CHAR_A + {2'b00, d} - {2'b00, DEC_BASE};
        end
        return c;
    endfunction

endpackage

// ===== src/frta_divider.sv =====
// Bit-serial restoring divider: dividend over a small radix, one quotient bit per cycle.
module frta_divider #(
    parameter int W = frta_pkg::INT_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [W-1:0]                i_dividend,
    input  logic [frta_pkg::DIGIT_W-1:0] i_divisor,
    output logic                        o_done,
    output logic [W-1:0]                o_quotient,
    output logic [frta_pkg::DIGIT_W-1:0] o_remainder
);
    import frta_pkg::*;

    localparam int CNT_W = $clog2(W + 1);

    logic                r_busy;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    logic [W-1:0]        r_quo;
    logic [DIGIT_W-1:0]  r_rem;
    logic [DIGIT_W-1:0]  r_div;
    logic [DIGIT_W:0]    trial;
    logic                fits;

    always_comb begin
        trial = {r_rem, r_quo[W-1]};
        fits  = (trial >= {1'b0, r_div});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(W);
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_quo <= {r_quo[W-2:0], fits};
                if (fits) begin
                    r_rem <= DIGIT_W'(trial - {1'b0, r_div});
                end else begin
                    r_rem <= trial[DIGIT_W-1:0];
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

// ===== src/fixed_point_radix_to_ascii.sv =====
// Top level: microcoded sequencer that prints a sign-magnitude fixed-point number as ASCII.
//
//  channel   dir  handshake              payload
//  s (in)    in   i_s_tvalid/o_s_tready  tuser: is_negative; tdata: integer, fraction
//  m (out)   out  o_m_tvalid/i_m_tready  tdata: ascii_char; tlast: is_last
//  cfg       in   i_cfg_we               i_cfg_index, i_cfg_wdata
//
// One number at a time: the sequencer loads it, emits any minus sign, runs the bit-serial
// divider once per integer digit, then emits the integer digits, the point and the fraction
// digits. Characters leave through a one-word output register.
// Synchronous active-low reset clears sequencer and output valid and sets the configuration to its defaults.
// A stalled output holds the sequencer on its emitting step.
module fixed_point_radix_to_ascii #(
    parameter int INT_BITS        = frta_pkg::INT_BITS_DEF,
    parameter int FRAC_BITS       = frta_pkg::FRAC_BITS_DEF,
    parameter int MAX_FRAC_DIGITS = frta_pkg::MAX_FRAC_DIGITS_DEF,
    parameter int S_TDATA_W       = ((INT_BITS + FRAC_BITS + 7) / 8) * 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // [INT_BITS-1:0] integer_magnitude, [INT_BITS+FRAC_BITS-1:INT_BITS] fraction_bits
    input  logic [S_TDATA_W-1:0]          i_s_tdata,
    // [0] is_negative
    input  logic                          i_s_tuser,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // [7:0] ascii_char
    output logic [frta_pkg::CHAR_W-1:0]   o_m_tdata,
    output logic                          o_m_tlast,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [frta_pkg::DIGIT_W-1:0]  i_cfg_wdata
);
    import frta_pkg::*;

    localparam int CW = $clog2(INT_BITS + 1);
    localparam int IW = $clog2(INT_BITS);
    localparam int KW = $clog2(MAX_FRAC_DIGITS + 1);
    localparam longint unsigned FRAC_THRESH = ((64'd1 << FRAC_BITS) + 64'd99) / 64'd100;

    typedef enum logic [2:0] {
        S_IDLE, S_SIGN, S_DIVCHK, S_DIVWAIT, S_INTOUT, S_POINT, S_FRAC
    } t_step;

    typedef enum logic [2:0] {
        C_NONE, C_POS, C_INT_DONE, C_CNT_ZERO, C_FRAC_DONE
    } t_cond;

    typedef enum logic [2:0] {
        A_LOAD, A_EMIT_MINUS, A_DIV_START, A_DIV_STORE, A_EMIT_INT, A_EMIT_POINT,
        A_EMIT_FRAC
    } t_act;

    typedef struct packed {
        t_cond cond;
        t_step jmp;
        t_act  act;
        t_step nxt;
    } t_uword;

    function automatic t_uword ucode(input t_step s);
        t_uword w;
        case (s)
            S_IDLE:    w = '{C_NONE,      S_IDLE,   A_LOAD,       S_SIGN};
            S_SIGN:    w = '{C_POS,       S_DIVCHK, A_EMIT_MINUS, S_DIVCHK};
            S_DIVCHK:  w = '{C_INT_DONE,  S_INTOUT, A_DIV_START,  S_DIVWAIT};
            S_DIVWAIT: w = '{C_NONE,      S_IDLE,   A_DIV_STORE,  S_DIVCHK};
            S_INTOUT:  w = '{C_CNT_ZERO,  S_POINT,  A_EMIT_INT,   S_INTOUT};
            S_POINT:   w = '{C_NONE,      S_IDLE,   A_EMIT_POINT, S_FRAC};
            S_FRAC:    w = '{C_FRAC_DONE, S_IDLE,   A_EMIT_FRAC,  S_FRAC};
            default:   w = '{C_NONE,      S_IDLE,   A_LOAD,       S_SIGN};
        endcase
        return w;
    endfunction

    t_step                r_step;
    logic [DIGIT_W-1:0]   r_cfg_radix;
    logic [LIMIT_W-1:0]   r_cfg_limit;
    logic [DIGIT_W-1:0]   r_base;
    logic [KW-1:0]        r_limit;
    logic [KW-1:0]        r_k;
    logic                 r_neg;
    logic [INT_BITS-1:0]  r_work;
    logic [FRAC_BITS-1:0] r_frac;
    logic [CW-1:0]        r_count;
    logic [DIGIT_W-1:0]   r_store [INT_BITS];
    logic                 r_out_valid;
    logic [CHAR_W-1:0]    r_out_char;
    logic                 r_out_last;

    t_uword                       uw;
    logic                         cond_true;
    logic                         act_go;
    logic                         emit;
    logic                         out_free;
    logic                         s_accept;
    logic                         div_start;
    logic                         div_done;
    logic [INT_BITS-1:0]          div_quo;
    logic [DIGIT_W-1:0]           div_rem;
    logic [FRAC_BITS+DIGIT_W-1:0] prod;
    logic [FRAC_BITS-1:0]         prod_frac;
    logic                         frac_small;
    logic                         prod_small;
    logic [CW-1:0]                rd_idx;
    logic [DIGIT_W-1:0]           n_base;
    logic [KW-1:0]                n_limit;

    assign o_s_tready = (r_step == S_IDLE);
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_valid || i_m_tready;

    always_comb begin
        uw         = ucode(r_step);
        prod       = {{DIGIT_W{1'b0}}, r_frac} * {{FRAC_BITS{1'b0}}, r_base};
        prod_frac  = prod[FRAC_BITS-1:0];
        frac_small = (64'(r_frac) < FRAC_THRESH);
        prod_small = (64'(prod_frac) < FRAC_THRESH);
        rd_idx     = r_count - 1'b1;

        if (r_cfg_radix < RADIX_MIN) begin
            n_base = RADIX_MIN;
        end else if (r_cfg_radix > RADIX_MAX) begin
            n_base = RADIX_MAX;
        end else begin
            n_base = r_cfg_radix;
        end
        if (32'(r_cfg_limit) > MAX_FRAC_DIGITS) begin
            n_limit = KW'(MAX_FRAC_DIGITS);
        end else begin
            n_limit = KW'(r_cfg_limit);
        end

        case (uw.cond)
            C_POS:       cond_true = !r_neg;
            C_INT_DONE:  cond_true = (r_work == '0) || (r_count == CW'(INT_BITS));
            C_CNT_ZERO:  cond_true = (r_count == '0);
            C_FRAC_DONE: cond_true = (r_k == r_limit) || frac_small;
            default:     cond_true = 1'b0;
        endcase

        case (uw.act)
            A_LOAD:      act_go = s_accept;
            A_DIV_START: act_go = 1'b1;
            A_DIV_STORE: act_go = div_done;
            default:     act_go = out_free;
        endcase

        emit = !cond_true && act_go &&
               ((uw.act == A_EMIT_MINUS) || (uw.act == A_EMIT_INT) ||
                (uw.act == A_EMIT_POINT) || (uw.act == A_EMIT_FRAC));

        div_start = !cond_true && (uw.act == A_DIV_START);
    end

    frta_divider #(
        .W (INT_BITS)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (r_work),
        .i_divisor   (r_base),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!cond_true && act_go && uw.act == A_DIV_STORE) begin
            r_store[r_count[IW-1:0]] <= div_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= S_IDLE;
            r_cfg_radix <= RADIX_RESET;
            r_cfg_limit <= LIMIT_RESET;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_work      <= '0;
            r_frac      <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_RADIX) begin
                    r_cfg_radix <= i_cfg_wdata;
                end else begin
                    r_cfg_limit <= i_cfg_wdata[LIMIT_W-1:0];
                end
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (cond_true) begin
                r_step <= uw.jmp;
            end else if (act_go) begin
                r_step <= uw.nxt;
                case (uw.act)
                    A_LOAD: begin
                        r_neg   <= i_s_tuser;
                        r_work  <= i_s_tdata[INT_BITS-1:0];
                        r_frac  <= i_s_tdata[INT_BITS+FRAC_BITS-1:INT_BITS];
                        r_count <= '0;
                        r_k     <= '0;
                        r_base  <= n_base;
                        r_limit <= n_limit;
                    end
                    A_EMIT_MINUS: begin
                        r_out_char  <= CHAR_MINUS;
                        r_out_last  <= 1'b0;
                    end
                    A_DIV_START: begin
                    end
                    A_DIV_STORE: begin
                        r_work  <= div_quo;
                        r_count <= r_count + 1'b1;
                    end
                    A_EMIT_INT: begin
                        r_out_char  <= digit_char(r_store[rd_idx[IW-1:0]]);
                        r_out_last  <= 1'b0;
                        r_count     <= rd_idx;
                    end
                    A_EMIT_POINT: begin
                        r_out_char  <= CHAR_POINT;
                        r_out_last  <= (r_limit == '0) || frac_small;
                    end
                    A_EMIT_FRAC: begin
                        r_out_char  <= digit_char(prod[FRAC_BITS+DIGIT_W-1:FRAC_BITS]);
                        r_out_last  <= (r_k + 1'b1 == r_limit) || prod_small;
                        r_frac      <= prod_frac;
                        r_k         <= r_k + 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_char;
    assign o_m_tlast  = r_out_last;

endmodule
